/* src/cpcq_pkg.sv */
package cpcq_pkg;

  // what one handshake moves on the input side
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_COAL   = 2'd0;
  localparam logic [1:0] ST_FREE   = 2'd1;
  localparam logic [1:0] ST_EVICT  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // slots of the index bundle carried by the scan token
  localparam int SEL_MATCH = 0;
  localparam int SEL_FREE  = 1;
  localparam int SEL_MAX   = 2;
  localparam int SEL_MIN   = 3;
  localparam int SEL_N     = 4;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        is_set;
    logic [7:0]  prio;
    logic [3:0]  attempts;
    logic        long_timeout;
    logic [31:0] payload;
    logic [2:0]  payload_bytes;
    logic [7:0]  response_length;
    logic [15:0] value_word;
  } entry_t;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic       match_hit;
    logic [3:0] match_att;
    logic       free_hit;
    logic [7:0] max_prio;
    logic       min_hit;
    entry_t     min_ent;
  } scan_t;

  // update broadcast to all cells at the end of a scan
  typedef struct packed {
    logic   wr;
    logic   pop;
    logic   clr;
    entry_t ent;
  } act_t;

endpackage

/* src/cpcq_cell.sv */
module cpcq_cell
  import cpcq_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int CELL_IDX = 0,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  entry_t                          req,
  input  act_t                            act,
  input  logic [IDX_W-1:0]                act_idx,
  input  logic                            tok_vld_in,
  input  scan_t                           tok_in,
  input  logic [SEL_N-1:0][IDX_W-1:0]     idx_in,
  output logic                            tok_vld_out,
  output scan_t                           tok_out,
  output logic [SEL_N-1:0][IDX_W-1:0]     idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                        slot_vld;
  entry_t                      slot;
  scan_t                       tok_next;
  logic [SEL_N-1:0][IDX_W-1:0] idx_next;
  logic                        sel;

  assign sel = (act_idx == MY_IDX);

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    // first occupied slot with the same key
    if (!tok_in.match_hit && slot_vld && slot.opcode == req.opcode &&
        slot.is_set == req.is_set) begin
      tok_next.match_hit  = 1'b1;
      tok_next.match_att  = slot.attempts;
      idx_next[SEL_MATCH] = MY_IDX;
    end
    if (!tok_in.free_hit && !slot_vld) begin
      tok_next.free_hit  = 1'b1;
      idx_next[SEL_FREE] = MY_IDX;
    end
    // eviction candidate, only used when every slot is occupied
    if (slot.prio > tok_in.max_prio) begin
      tok_next.max_prio = slot.prio;
      idx_next[SEL_MAX] = MY_IDX;
    end
    if (slot_vld && (!tok_in.min_hit || slot.prio < tok_in.min_ent.prio)) begin
      tok_next.min_hit  = 1'b1;
      tok_next.min_ent  = slot;
      idx_next[SEL_MIN] = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld_out <= 1'b0;
      slot_vld    <= 1'b0;
    end else begin
      tok_vld_out <= tok_vld_in;
      if (act.clr) begin
        slot_vld <= 1'b0;
      end else if (act.wr && sel) begin
        slot_vld <= 1'b1;
      end else if (act.pop && sel) begin
        slot_vld <= 1'b0;
      end
    end
    tok_out <= tok_next;
    idx_out <= idx_next;
    if (act.wr && sel) begin
      slot <= act.ent;
    end
  end

endmodule

/* src/coalescing_priority_command_queue.sv */
// channel | signals                            | direction
// --------+------------------------------------+----------
// in      | in_valid, in_ready, mode .. value  | into block
// out     | out_valid, out_ready, push_status  | out of block
//         | .. out_value_word, drop_total      |
//
// the result is registered after the item is accepted through a launch step, the
// scan token walking the cell row one slot per cycle, and the update step; the
// next item is taken only once the block is back in idle
// reset clears all slot valid bits, the drop count and the output valid flag
// a stalled result holds the update step; no new item is accepted meanwhile
module coalescing_priority_command_queue
  import cpcq_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  opcode,
  input  logic        is_set,
  input  logic [7:0]  priority_req,
  input  logic [3:0]  attempts,
  input  logic        long_timeout,
  input  logic [31:0] payload,
  input  logic [2:0]  payload_bytes,
  input  logic [7:0]  response_length,
  input  logic [15:0] value_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  push_status,
  output logic        entry_valid,
  output logic [7:0]  out_opcode,
  output logic        out_is_set,
  output logic [7:0]  out_priority,
  output logic [3:0]  out_attempts,
  output logic        out_long_timeout,
  output logic [31:0] out_payload,
  output logic [2:0]  out_payload_bytes,
  output logic [7:0]  out_response_length,
  output logic [15:0] out_value_word,
  output logic [31:0] drop_total
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_DONE
  } state_t;

  state_t      state;
  mode_t       req_mode;
  entry_t      req;
  entry_t      out_ent;
  logic [31:0] drop_cnt;

  logic                        chain_vld [SLOT_COUNT+1];
  scan_t                       chain_tok [SLOT_COUNT+1];
  logic [SEL_N-1:0][IDX_W-1:0] chain_idx [SLOT_COUNT+1];

  scan_t                       tail;
  logic [SEL_N-1:0][IDX_W-1:0] tail_idx;
  logic                        tail_vld;

  act_t             act;
  logic [IDX_W-1:0] act_idx;
  logic             fire;
  logic [1:0]       status_next;
  logic             hit_next;
  entry_t           ent_next;
  logic [31:0]      drop_next;

  assign chain_vld[0] = (state == S_LAUNCH);
  assign chain_tok[0] = '0;
  assign chain_idx[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    cpcq_cell #(
      .SLOT_COUNT(SLOT_COUNT),
      .CELL_IDX  (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .req        (req),
      .act        (act),
      .act_idx    (act_idx),
      .tok_vld_in (chain_vld[i]),
      .tok_in     (chain_tok[i]),
      .idx_in     (chain_idx[i]),
      .tok_vld_out(chain_vld[i+1]),
      .tok_out    (chain_tok[i+1]),
      .idx_out    (chain_idx[i+1])
    );
  end

  assign tail     = chain_tok[SLOT_COUNT];
  assign tail_idx = chain_idx[SLOT_COUNT];
  assign tail_vld = chain_vld[SLOT_COUNT];

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    act         = '0;
    act.ent     = req;
    act_idx     = '0;
    status_next = ST_COAL;
    hit_next    = 1'b0;
    ent_next    = '0;
    drop_next   = drop_cnt;
    case (req_mode)
      MODE_PUSH: begin
        if (tail.match_hit) begin
          act.wr  = fire;
          act_idx = tail_idx[SEL_MATCH];
          if (tail.match_att > req.attempts) begin
            act.ent.attempts = tail.match_att;
          end
        end else if (tail.free_hit) begin
          act.wr      = fire;
          act_idx     = tail_idx[SEL_FREE];
          status_next = ST_FREE;
        end else begin
          drop_next = drop_cnt + 32'd1;
          act_idx   = tail_idx[SEL_MAX];
          if (tail.max_prio >= req.prio) begin
            act.wr      = fire;
            status_next = ST_EVICT;
          end else begin
            status_next = ST_REJECT;
          end
        end
      end
      MODE_POP: begin
        if (tail.min_hit) begin
          act.pop  = fire;
          act_idx  = tail_idx[SEL_MIN];
          hit_next = 1'b1;
          ent_next = tail.min_ent;
        end
      end
      MODE_CLEAR: begin
        act.clr = fire;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      drop_cnt  <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (tail_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            drop_cnt <= drop_next;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (in_valid && in_ready) begin
      req_mode            <= mode_t'(mode);
      req.opcode          <= opcode;
      req.is_set          <= is_set;
      req.prio            <= priority_req;
      req.attempts        <= attempts;
      req.long_timeout    <= long_timeout;
      req.payload         <= payload;
      req.payload_bytes   <= payload_bytes;
      req.response_length <= response_length;
      req.value_word      <= value_word;
    end
    if (fire) begin
      push_status <= status_next;
      entry_valid <= hit_next;
      out_ent     <= ent_next;
    end
  end

  assign out_opcode          = out_ent.opcode;
  assign out_is_set          = out_ent.is_set;
  assign out_priority        = out_ent.prio;
  assign out_attempts        = out_ent.attempts;
  assign out_long_timeout    = out_ent.long_timeout;
  assign out_payload         = out_ent.payload;
  assign out_payload_bytes   = out_ent.payload_bytes;
  assign out_response_length = out_ent.response_length;
  assign out_value_word      = out_ent.value_word;
  assign drop_total          = drop_cnt;

  a_drop_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(drop_cnt))
    else $error("drop count moved outside the update step");

  a_pop_no_push_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> (push_status == ST_COAL))
    else $error("popped item carries a push status");

  a_single_action: assert property (@(posedge clk) disable iff (rst)
    act.wr |-> (!act.pop && !act.clr && fire))
    else $error("conflicting slot updates");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail_vld |-> (state == S_SCAN))
    else $error("scan token left the row outside the scan");

endmodule
